/* hdl/lzwe_pkg.sv */
// ============================================================================
// lzwe_pkg
// Shared types, constants and helper functions for the LZW encoder.
// ============================================================================
`default_nettype none

package lzwe_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES = 4096;
    localparam int MAX_CODE_BITS = 12;
    localparam int CODE_SPACE    = (TABLE_ENTRIES < (1 << MAX_CODE_BITS)) ?
                                   TABLE_ENTRIES : (1 << MAX_CODE_BITS);
    localparam int CW            = $clog2(TABLE_ENTRIES);
    localparam int LIM_W         = CW + 1;
    localparam int ACC_W         = 20;
    localparam int HELD_W        = 5;

    localparam logic [CW-1:0]    EMPTY_LINK = CW'(TABLE_ENTRIES - 1);
    localparam logic [CW-1:0]    FULL_CODE  = CW'(CODE_SPACE - 2);
    localparam logic [3:0]       CFG_RESET  = 4'd8;

    // Input and output beats.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_in_run;
        logic       stream_done;
    } t_out;

    // Code source for an emit.
    typedef enum logic [1:0] {
        EM_PREFIX = 2'd0,
        EM_CLEAR  = 2'd1,
        EM_END    = 2'd2
    } t_emit;

    // One node of the string table.
    typedef struct packed {
        logic [CW-1:0] prefix;
        logic [CW-1:0] sib;
        logic [7:0]    sym;
    } t_node;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  take;
        logic  start;
        logic  restart;
        logic  emit;
        t_emit emit_sel;
        logic  prefix_sym;
        logic  rd_fc;
        logic  rd_node_fc;
        logic  rd_node_sib;
        logic  head_fc;
        logic  head_empty;
        logic  found;
        logic  add;
        logic  push;
        logic  flush;
        logic  fin;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_stream;
        logic prefix_valid;
        logic last;
        logic held_ge8;
        logic held_nz;
        logic fc_in_range;
        logic node_pfx_match;
        logic node_sym_match;
        logic sib_empty;
        logic free_full;
        logic can_push;
        logic hold_valid;
        logic out_free;
    } t_sts;

    // Clamp the configured symbol width to its legal range.
    function automatic logic [3:0] eff_bits(input logic [3:0] cfg);
        logic [3:0] e;
        e = cfg;
        if (cfg < 4'd2) e = 4'd2;
        if (cfg > 4'd8) e = 4'd8;
        return e;
    endfunction

    // Code value at which the code width must grow, capped below the table size.
    function automatic logic [LIM_W-1:0] limit_for(input logic [3:0] w);
        logic [16:0] l;
        l = 17'd1 << w;
        if (l >= 17'(CODE_SPACE - 1)) l = 17'(CODE_SPACE - 2);
        return l[LIM_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/lzw_variable_width_encoder.sv */
// ============================================================================
// lzw_variable_width_encoder
// GIF-style variable-width LZW compressor with a 12-bit chained string table.
// ============================================================================
// Usage:
//   The input channel takes one symbol beat (data_byte, last_byte) at a time.
//   The output channel delivers packed code bytes, LSB first; last_in_run
//   marks the final byte caused by one input beat and stream_done the final
//   byte of the stream. initial_bits is written through i_cfg_we/i_cfg_wdata
//   when no stream is open and takes effect at the start of the next stream.
//   One symbol is processed at a time. A beat whose string is found walks
//   the sibling chain from its head node until the symbol matches. A miss
//   walks the chain, emits the prefix code, drains its output bytes and
//   adds a table node; a table-full clear adds a clear code and its bytes.
//   The first beat of a stream starts with a clear code and its bytes. A
//   last beat adds three emits and a flush.
//   Stale table links after a clear are rejected by checking each head
//   node's stored prefix and code range, so no clearing pass is needed.
//   Reset returns to idle, with initial_bits at 8 and no stream open.
//   When the receiver stalls, one byte waits in the output register and one
//   in a hold stage; the sequencer then pauses until there is room.
// ============================================================================
`default_nettype none

module lzw_variable_width_encoder
    import lzwe_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [3:0] i_cfg_wdata,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output t_out       o_out_data
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer.
    lzwe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Table, code state and packer.
    lzwe_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

/* hdl/lzwe_ctrl.sv */
// ============================================================================
// lzwe_ctrl
// Sequencer for the LZW encoder: walks the table chain and orders the emits.
// ============================================================================
`default_nettype none

module lzwe_ctrl
    import lzwe_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [14:0] {
        ST_IDLE  = 15'b000000000000001,
        ST_START = 15'b000000000000010,
        ST_SCLR  = 15'b000000000000100,
        ST_PROC  = 15'b000000000001000,
        ST_FC    = 15'b000000000010000,
        ST_NODE  = 15'b000000000100000,
        ST_MISS  = 15'b000000001000000,
        ST_ADD   = 15'b000000010000000,
        ST_FULL  = 15'b000000100000000,
        ST_TAIL  = 15'b000001000000000,
        ST_END2  = 15'b000010000000000,
        ST_END3  = 15'b000100000000000,
        ST_DRAIN = 15'b001000000000000,
        ST_FLUSH = 15'b010000000000000,
        ST_FIN   = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic   r_first, n_first;

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_first <= n_first;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_first = r_first;
        o_cmd   = '0;
        o_cmd.emit_sel = EM_PREFIX;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state = i_sts.in_stream ? ST_PROC : ST_START;
                end
            end
            ST_START: begin
                o_cmd.start = 1'b1;
                n_state = ST_SCLR;
            end
            ST_SCLR: begin
                o_cmd.emit = 1'b1;
                o_cmd.emit_sel = EM_CLEAR;
                n_ret   = ST_PROC;
                n_state = ST_DRAIN;
            end
            ST_PROC: begin
                if (!i_sts.prefix_valid) begin
                    o_cmd.prefix_sym = 1'b1;
                    n_state = ST_TAIL;
                end else begin
                    o_cmd.rd_fc = 1'b1;
                    n_state = ST_FC;
                end
            end
            ST_FC: begin
                if (i_sts.fc_in_range) begin
                    o_cmd.rd_node_fc = 1'b1;
                    n_first = 1'b1;
                    n_state = ST_NODE;
                end else begin
                    o_cmd.head_empty = 1'b1;
                    n_state = ST_MISS;
                end
            end
            ST_NODE: begin
                n_first = 1'b0;
                if (r_first && !i_sts.node_pfx_match) begin
                    // Head link left over from an earlier table.
                    o_cmd.head_empty = 1'b1;
                    n_state = ST_MISS;
                end else begin
                    o_cmd.head_fc = r_first;
                    if (i_sts.node_sym_match) begin
                        o_cmd.found = 1'b1;
                        n_state = ST_TAIL;
                    end else if (i_sts.sib_empty) begin
                        n_state = ST_MISS;
                    end else begin
                        o_cmd.rd_node_sib = 1'b1;
                    end
                end
            end
            ST_MISS: begin
                o_cmd.emit = 1'b1;
                o_cmd.emit_sel = EM_PREFIX;
                n_ret   = ST_ADD;
                n_state = ST_DRAIN;
            end
            ST_ADD: begin
                o_cmd.add = 1'b1;
                n_state = ST_FULL;
            end
            ST_FULL: begin
                if (i_sts.free_full) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_sel = EM_CLEAR;
                    o_cmd.restart = 1'b1;
                    n_ret   = ST_TAIL;
                    n_state = ST_DRAIN;
                end else begin
                    n_state = ST_TAIL;
                end
            end
            ST_TAIL: begin
                if (i_sts.last) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_sel = EM_PREFIX;
                    n_ret   = ST_END2;
                    n_state = ST_DRAIN;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_END2: begin
                o_cmd.emit = 1'b1;
                o_cmd.emit_sel = EM_CLEAR;
                n_ret   = ST_END3;
                n_state = ST_DRAIN;
            end
            ST_END3: begin
                o_cmd.emit = 1'b1;
                o_cmd.emit_sel = EM_END;
                n_ret   = ST_FLUSH;
                n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!i_sts.held_ge8) begin
                    n_state = r_ret;
                end else if (i_sts.can_push) begin
                    o_cmd.push = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (!i_sts.held_nz || i_sts.can_push) begin
                    o_cmd.flush = 1'b1;
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!i_sts.hold_valid) begin
                    n_state = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/lzwe_dpath.sv */
// ============================================================================
// lzwe_dpath
// Datapath of the LZW encoder: string table, code state, bit packer, output.
// ============================================================================
`default_nettype none

module lzwe_dpath
    import lzwe_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [3:0] i_cfg_wdata,
    input  t_in        i_in_data,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output t_out       o_out_data
);

    logic [3:0]       r_cfg;
    logic [7:0]       r_sym;
    logic             r_last;
    logic [CW-1:0]    r_prefix;
    logic             r_prefix_valid;
    logic             r_in_stream;
    logic [CW-1:0]    r_free;
    logic [3:0]       r_width;
    logic [LIM_W-1:0] r_limit;
    logic [ACC_W-1:0] r_acc;
    logic [HELD_W-1:0] r_held;
    logic [CW-1:0]    r_seeker;
    logic [CW-1:0]    r_head;
    logic             r_hold_valid;
    logic [7:0]       r_hold;
    logic             r_out_valid;
    t_out             r_out;

    logic [CW-1:0]    r_fc_mem [TABLE_ENTRIES];
    t_node            r_node_mem [TABLE_ENTRIES];
    logic [CW-1:0]    r_fc_rd;
    t_node            r_node_rd;

    logic [3:0]       eff;
    logic [CW-1:0]    clear_code;
    logic [CW-1:0]    n_free;
    logic [3:0]       w_sel;
    logic [CW-1:0]    code_sel;
    logic [16:0]      mask_full;
    logic [CW-1:0]    masked;
    logic [ACC_W-1:0] acc_add;
    logic             out_free;
    logic             can_push;
    logic             do_push;
    logic [CW-1:0]    node_addr;
    logic             node_rd_en;

    assign eff        = eff_bits(r_cfg);
    assign clear_code = CW'(1) << eff;
    assign n_free     = r_free + CW'(1);
    assign out_free   = !r_out_valid || i_out_ready;
    assign can_push   = !r_hold_valid || out_free;
    assign do_push    = i_cmd.push || (i_cmd.flush && (r_held != '0));

    // Code selection and masking for an emit.
    always_comb begin
        w_sel = (i_cmd.emit_sel == EM_END) ? (eff + 4'd1) : r_width;
        case (i_cmd.emit_sel)
            EM_PREFIX: code_sel = r_prefix;
            EM_CLEAR:  code_sel = clear_code;
            EM_END:    code_sel = clear_code + CW'(1);
            default:   code_sel = r_prefix;
        endcase
        mask_full = (17'd1 << w_sel) - 17'd1;
        masked    = code_sel & mask_full[CW-1:0];
        acc_add   = ACC_W'(masked) << r_held;
    end

    // Status toward the controller.
    always_comb begin
        o_sts.in_stream      = r_in_stream;
        o_sts.prefix_valid   = r_prefix_valid;
        o_sts.last           = r_last;
        o_sts.held_ge8       = (r_held >= HELD_W'(8));
        o_sts.held_nz        = (r_held != '0);
        o_sts.fc_in_range    = (r_fc_rd >= clear_code + CW'(2)) && (r_fc_rd <= r_free)
                               && (r_fc_rd != EMPTY_LINK);
        o_sts.node_pfx_match = (r_node_rd.prefix == r_prefix);
        o_sts.node_sym_match = (r_node_rd.sym == r_sym);
        o_sts.sib_empty      = (r_node_rd.sib == EMPTY_LINK);
        o_sts.free_full      = (r_free >= FULL_CODE);
        o_sts.can_push       = can_push;
        o_sts.hold_valid     = r_hold_valid;
        o_sts.out_free       = out_free;
    end

    // Table memories: registered reads, one write port each.
    always_comb begin
        node_addr  = i_cmd.rd_node_fc ? r_fc_rd : r_node_rd.sib;
        node_rd_en = i_cmd.rd_node_fc || i_cmd.rd_node_sib;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_fc) begin
            r_fc_rd <= r_fc_mem[r_prefix];
        end
        if (node_rd_en) begin
            r_node_rd <= r_node_mem[node_addr];
        end
        if (i_cmd.add && (n_free < EMPTY_LINK)) begin
            r_fc_mem[r_prefix]  <= n_free;
            r_node_mem[n_free]  <= '{prefix: r_prefix, sib: r_head, sym: r_sym};
        end
    end

    // Chain walk payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_sym  <= i_in_data.data_byte & 8'((9'd1 << eff) - 9'd1);
            r_last <= i_in_data.last_byte;
        end
        if (i_cmd.rd_node_fc) begin
            r_seeker <= r_fc_rd;
        end else if (i_cmd.rd_node_sib) begin
            r_seeker <= r_node_rd.sib;
        end
        if (i_cmd.head_empty) begin
            r_head <= EMPTY_LINK;
        end else if (i_cmd.head_fc) begin
            r_head <= r_seeker;
        end
    end

    // Stream and code state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg          <= CFG_RESET;
            r_prefix       <= '0;
            r_prefix_valid <= 1'b0;
            r_in_stream    <= 1'b0;
            r_free         <= (CW'(1) << eff_bits(CFG_RESET)) + CW'(1);
            r_width        <= eff_bits(CFG_RESET) + 4'd1;
            r_limit        <= limit_for(eff_bits(CFG_RESET) + 4'd1);
        end else begin
            if (i_cfg_we && !r_in_stream) begin
                r_cfg <= i_cfg_wdata;
            end
            if (i_cmd.start || i_cmd.restart) begin
                r_free  <= clear_code + CW'(1);
                r_width <= eff + 4'd1;
                r_limit <= limit_for(eff + 4'd1);
            end
            if (i_cmd.emit && (i_cmd.emit_sel == EM_END)) begin
                r_width <= eff + 4'd1;
            end
            if (i_cmd.start) begin
                r_prefix       <= '0;
                r_prefix_valid <= 1'b0;
                r_in_stream    <= 1'b1;
            end
            if (i_cmd.prefix_sym) begin
                r_prefix       <= CW'(r_sym);
                r_prefix_valid <= 1'b1;
            end
            if (i_cmd.found) begin
                r_prefix <= r_seeker;
            end
            if (i_cmd.add) begin
                r_free   <= n_free;
                r_prefix <= CW'(r_sym);
                if ((LIM_W'(n_free) >= r_limit) && (n_free < FULL_CODE)) begin
                    r_width <= r_width + 4'd1;
                    r_limit <= limit_for(r_width + 4'd1);
                end
            end
            if (i_cmd.flush) begin
                r_in_stream    <= 1'b0;
                r_prefix_valid <= 1'b0;
                r_prefix       <= '0;
            end
        end
    end

    // Bit packer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_held <= '0;
        end else if (i_cmd.start || i_cmd.flush) begin
            r_acc  <= '0;
            r_held <= '0;
        end else if (i_cmd.emit) begin
            r_acc  <= r_acc | acc_add;
            r_held <= r_held + HELD_W'(w_sel);
        end else if (i_cmd.push) begin
            r_acc  <= r_acc >> 8;
            r_held <= r_held - HELD_W'(8);
        end
    end

    // One-byte hold stage and output register. The hold stage keeps the newest
    // byte back so it can be tagged as the last of its run.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else if (do_push) begin
            r_hold       <= r_acc[7:0];
            r_hold_valid <= 1'b1;
            if (r_hold_valid) begin
                r_out       <= '{out_byte: r_hold, last_in_run: 1'b0, stream_done: 1'b0};
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end else if (i_cmd.fin) begin
            r_hold_valid <= 1'b0;
            r_out        <= '{out_byte: r_hold, last_in_run: 1'b1, stream_done: r_last};
            r_out_valid  <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* hdl/lzwe_checker.sv */
// ============================================================================
// lzwe_checker
// Port-level checks for the LZW encoder, bound to the top level.
// ============================================================================
`default_nettype none

module lzwe_checker
    import lzwe_pkg::*;
(
    input wire  i_clk,
    input wire  i_rst_n,
    input wire  i_in_valid,
    input wire  o_in_ready,
    input wire  o_out_valid,
    input wire  i_out_ready,
    input t_out o_out_data
);

    // A stalled output beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // The end of a stream is also the end of its run.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.stream_done |-> o_out_data.last_in_run)
        else $error("stream_done without last_in_run");

    // One symbol at a time: an accepted beat closes the input.
    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while busy");

    // Nothing is shown just after reset.
    a_reset_clean: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_out_valid && o_in_ready)
        else $error("output or busy state after reset");

endmodule

bind lzw_variable_width_encoder lzwe_checker u_lzwe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
